[hw/rtl/piecewise_linear_table_interpolator_macros.svh]
// Assertion macros for the piecewise linear table interpolator checker.
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLTI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interpolator check failed");

// Next-cycle implication, disabled during reset.
`define PLTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interpolator check failed");

`endif

[hw/rtl/plti_pkg.sv]
// Shared types and constants of the piecewise linear table interpolator.
package plti_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int NUM_W      = 7;
   localparam int DIV_STEPS  = 32;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] RGN_INSIDE = 2'd0;
   localparam logic [1:0] RGN_BELOW  = 2'd1;
   localparam logic [1:0] RGN_ABOVE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Query token that walks down the cell row.
   typedef struct packed {
      logic               valid;
      logic               fin;
      logic               matched;
      logic [1:0]         region;
      logic signed [31:0] q;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
   } token_type;

   // Divider control and status.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_sts_type;

endpackage

[hw/rtl/plti_cell.sv]
// One breakpoint cell: holds one (x, y) pair and advances the query token.
module plti_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [plti_pkg::IDX_W-1:0]   wr_index,
   input  logic signed [31:0]           wr_x,
   input  logic signed [31:0]           wr_y,
   input  logic [plti_pkg::IDX_W-1:0]   cell_index,
   input  logic [plti_pkg::IDX_W-1:0]   last_index,
   input  plti_pkg::token_type          tok_in,
   output plti_pkg::token_type          tok_out
);
   import plti_pkg::*;

   logic signed [31:0] ex_ff;
   logic signed [31:0] ey_ff;
   token_type          tok_ff;
   token_type          tok_in_n;

   // Store the pair when a load targets this slot.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_index == cell_index)) begin
         ex_ff <= wr_x;
         ey_ff <= wr_y;
      end
   end

   // Evaluate this breakpoint against the token.
   always_comb begin
      tok_in_n    = tok_in;
      tok_in_n.px = ex_ff;
      tok_in_n.py = ey_ff;
      if (tok_in.valid && !tok_in.fin) begin
         if (cell_index == '0) begin
            if (tok_in.q <= ex_ff) begin
               tok_in_n.fin    = 1'b1;
               tok_in_n.region = RGN_BELOW;
               tok_in_n.y0     = ey_ff;
            end else if (last_index == '0) begin
               tok_in_n.fin    = 1'b1;
               tok_in_n.region = RGN_ABOVE;
               tok_in_n.y0     = ey_ff;
            end
         end else if (cell_index == last_index) begin
            tok_in_n.fin = 1'b1;
            if (tok_in.q >= ex_ff) begin
               tok_in_n.region = RGN_ABOVE;
               tok_in_n.y0     = ey_ff;
            end else begin
               tok_in_n.region = RGN_INSIDE;
               if (!tok_in.matched) begin
                  tok_in_n.x0 = tok_in.px;
                  tok_in_n.y0 = tok_in.py;
                  tok_in_n.x1 = ex_ff;
                  tok_in_n.y1 = ey_ff;
               end
            end
         end else if (!tok_in.matched && (tok_in.q <= ex_ff)) begin
            tok_in_n.matched = 1'b1;
            tok_in_n.x0      = tok_in.px;
            tok_in_n.y0      = tok_in.py;
            tok_in_n.x1      = ex_ff;
            tok_in_n.y1      = ey_ff;
         end
      end
   end

   // Hand the token to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;

endmodule

[hw/rtl/plti_div.sv]
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module plti_div (
   input  logic                   clock,
   input  logic                   reset,
   input  plti_pkg::div_ctl_type  ctl,
   input  logic [63:0]            dividend,
   input  logic [31:0]            divisor,
   output plti_pkg::div_sts_type  sts
);
   import plti_pkg::*;

   logic [31:0]       rem_ff;
   logic [31:0]       quo_ff;
   logic [31:0]       den_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [32:0]       trial;
   logic [32:0]       diff;

   // One shift and subtract step.
   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, den_ff};
   end

   // Control: count steps and flag completion.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            run_ff <= 1'b1;
            cnt_ff <= STEP_W'(DIV_STEPS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder and quotient shift registers.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= dividend[63:32];
         quo_ff <= dividend[31:0];
         den_ff <= divisor;
      end else if (run_ff) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

[hw/rtl/piecewise_linear_table_interpolator.sv]
// Sequence: a load is written at its transfer edge. A query token passes down the cell row, is
// captured, starts the divider, which runs its steps, and then the value is registered; a clamped
// result is registered from the captured token and skips the divider.
// Throughput: one item at a time; loads every cycle while idle, and after a query the next item
// is taken only once its result has been accepted at the output.
// Reset: synchronous; clears control state and sets points in use to 2; breakpoints not cleared.
module piecewise_linear_table_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // entry_index[5:0], point_x, point_y, query_x, pad
   input  logic [0:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // value
   output logic [1:0]   rsp_tuser,   // region
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data  // points_in_use
);
   import plti_pkg::*;

   state_type          state_ff, state_in;
   logic [NUM_W-1:0]   npts_ff;
   logic [IDX_W-1:0]   last_index;
   token_type          chain [MAX_POINTS+1];
   token_type          launch_tok;
   token_type          tok_ff;
   logic signed [31:0] value_ff, value_in;
   logic [1:0]         region_ff, region_in;
   logic               accept, wr_en;
   logic [IDX_W-1:0]   wr_index;
   logic signed [31:0] pt_x, pt_y, qx;
   logic [32:0]        num_w, den_w, mag_w, sum_w;
   logic               up;
   div_ctl_type        dctl;
   div_sts_type        dsts;
   logic [63:0]        product;

   assign wr_index = req_tdata[IDX_W-1:0];
   assign pt_x     = req_tdata[37:6];
   assign pt_y     = req_tdata[69:38];
   assign qx       = req_tdata[101:70];
   assign accept   = req_tvalid && req_tready;
   assign wr_en    = accept && (req_tuser[0] == FUNC_LOAD);

   // Hold the points-in-use register.
   always_ff @(posedge clock) begin
      if (reset) begin
         npts_ff <= NUM_W'(2);
      end else if (csr_wr_en) begin
         npts_ff <= csr_wr_data;
      end
   end

   // Clamp the count to the table size and form the last slot index.
   always_comb begin
      if (npts_ff == '0) begin
         last_index = '0;
      end else if (32'(npts_ff) > MAX_POINTS) begin
         last_index = IDX_W'(MAX_POINTS - 1);
      end else begin
         last_index = IDX_W'(npts_ff - 1'b1);
      end
   end

   // Launch a token into the first cell.
   always_comb begin
      launch_tok        = '0;
      launch_tok.valid  = accept && (req_tuser[0] == FUNC_QUERY);
      launch_tok.q      = qx;
      launch_tok.region = RGN_INSIDE;
   end

   assign chain[0] = launch_tok;

   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      plti_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_index   (wr_index),
         .wr_x       (pt_x),
         .wr_y       (pt_y),
         .cell_index (IDX_W'(g)),
         .last_index (last_index),
         .tok_in     (chain[g]),
         .tok_out    (chain[g+1])
      );
   end

   // Segment arithmetic from the captured token.
   always_comb begin
      num_w   = 33'(tok_ff.q) - 33'(tok_ff.x0);
      den_w   = 33'(tok_ff.x1) - 33'(tok_ff.x0);
      up      = (tok_ff.y1 >= tok_ff.y0);
      mag_w   = up ? (33'(tok_ff.y1) - 33'(tok_ff.y0))
                   : (33'(tok_ff.y0) - 33'(tok_ff.y1));
      product = num_w[31:0] * mag_w[31:0];
      sum_w   = up ? (33'(tok_ff.y0) + {1'b0, dsts.quotient})
                   : (33'(tok_ff.y0) - {1'b0, dsts.quotient});
   end

   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (product),
      .divisor  (den_w[31:0]),
      .sts      (dsts)
   );

   // Next state and outputs.
   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      region_in  = region_ff;
      dctl.start = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser[0] == FUNC_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[MAX_POINTS].valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            region_in = tok_ff.region;
            if ((tok_ff.region != RGN_INSIDE) || den_w[32] || (den_w == '0)) begin
               value_in = tok_ff.y0;
               state_in = ST_OUT;
            end else begin
               dctl.start = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dsts.done) begin
               value_in = sum_w[31:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance the state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the finished token and hold the result.
   always_ff @(posedge clock) begin
      if (chain[MAX_POINTS].valid) begin
         tok_ff <= chain[MAX_POINTS];
      end
      value_ff  <= value_in;
      region_ff <= region_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = region_ff;

endmodule

[hw/rtl/plti_checker.sv]
// Port-level checks for the piecewise linear table interpolator, bound to the top.
`include "piecewise_linear_table_interpolator_macros.svh"

module plti_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   import plti_pkg::*;

   // A result carries a defined region code.
   `PLTI_ASSERT_NOW(a_region_code, clock, reset, rsp_tvalid, rsp_tuser != 2'd3)
   // No new item is taken while a result waits.
   `PLTI_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // A query transfer closes the input until its result is taken; only the state just after the transfer is checked.
   `PLTI_ASSERT_NEXT(a_query_busy, clock, reset,
      req_tvalid && req_tready && (req_tuser[0] == FUNC_QUERY), !req_tready)
   // A stalled result holds its payload.
   `PLTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind piecewise_linear_table_interpolator plti_checker u_plti_checker (.*);
